### hdl/thermistor_table_temperature_assert.svh
// assertion macros shared by the rtl
`ifndef THERMISTOR_TABLE_TEMPERATURE_ASSERT_SVH
`define THERMISTOR_TABLE_TEMPERATURE_ASSERT_SVH

// same-cycle implication
`define TTT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ttt assertion failed");

// next-cycle implication
`define TTT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ttt assertion failed");

`endif

### hdl/ttt_pkg.sv
package ttt_pkg;

  localparam int unsigned QW = 37;   // widest dividend: 21-bit code times 16-bit supply

  localparam logic [2:0] REG_ADC_DIVISOR = 3'd0;
  localparam logic [2:0] REG_SUPPLY_MV   = 3'd1;
  localparam logic [2:0] REG_PULLUP      = 3'd2;
  localparam logic [2:0] REG_START_TEMP  = 3'd3;
  localparam logic [2:0] REG_TABLE_SIZE  = 3'd4;

  localparam logic [1:0] STAT_IN_RANGE = 2'd0;
  localparam logic [1:0] STAT_ABOVE    = 2'd1;
  localparam logic [1:0] STAT_BELOW    = 2'd2;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_MUL1 = 9'b000000010,
    ST_DIV1 = 9'b000000100,
    ST_MUL2 = 9'b000001000,
    ST_DIV2 = 9'b000010000,
    ST_RD   = 9'b000100000,
    ST_CMP  = 9'b001000000,
    ST_FRAC = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_e;

endpackage

### hdl/ttt_ram.sv
module ttt_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/ttt_mul.sv
// shift-add multiplier, one multiplier bit per cycle
module ttt_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [20:0]               a_i,
  input  logic [15:0]               b_i,
  output logic                      done_o,
  output logic [ttt_pkg::QW-1:0]    prod_o
);

  logic [ttt_pkg::QW-1:0] p_q;
  logic [4:0]             cnt_q;
  logic                   busy_q;
  logic [20:0]            a_q;
  logic [21:0]            sum;

  assign sum = {1'b0, p_q[ttt_pkg::QW-1:16]} + (p_q[0] ? {1'b0, a_q} : 22'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 5'd0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'd15) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {21'd0, b_i};
    end else if (busy_q) begin
      p_q <= {sum, p_q[15:1]};
    end
  end

  assign done_o = busy_q && (cnt_q == 5'd15);
  assign prod_o = {sum, p_q[15:1]};

endmodule

### hdl/ttt_div.sv
// restoring divider, one quotient bit per cycle
module ttt_div #(
  parameter int unsigned DW = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [ttt_pkg::QW-1:0] dividend_i,
  input  logic [DW-1:0]          rem_init_i,
  input  logic [DW-1:0]          divisor_i,
  input  logic [5:0]             steps_i,
  output logic                   done_o,
  output logic [ttt_pkg::QW-1:0] quo_o
);

  logic [ttt_pkg::QW-1:0] q_q;
  logic [DW-1:0]          rem_q;
  logic [DW-1:0]          d_q;
  logic [5:0]             left_q;
  logic                   busy_q;
  logic [DW:0]            trial;
  logic                   ge;
  logic [DW:0]            diff;

  assign trial = {rem_q, q_q[ttt_pkg::QW-1]};
  assign ge    = trial >= {1'b0, d_q};
  assign diff  = trial - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      left_q <= 6'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      left_q <= steps_i;
    end else if (busy_q) begin
      left_q <= left_q - 6'd1;
      if (left_q == 6'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= dividend_i;
      rem_q <= rem_init_i;
      d_q   <= divisor_i;
    end else if (busy_q) begin
      q_q   <= {q_q[ttt_pkg::QW-2:0], ge};
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign done_o = busy_q && (left_q == 6'd1);
  assign quo_o  = {q_q[ttt_pkg::QW-2:0], ge};

endmodule

### hdl/thermistor_table_temperature.sv
// load transaction: writes a table entry, no result
// convert transaction: a multiply and a divide give millivolts, then unless they saturate
//   a second multiply and divide give the resistance; the table is then searched with one ram
//   read per entry, a fraction division interpolates between entries, and the result is output
// one convert at a time; the next transaction is taken once the block is back in idle
// reset restores the register defaults; table contents are undefined until loaded
module thermistor_table_temperature #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned ENTRY_WIDTH = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,   // entry_index, entry_value, adc_code
  input  logic        s_axis_tuser_i,   // action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // temp_q8, resistance_value
  output logic [1:0]  m_axis_tuser_o,   // status
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [20:0] cfg_wdata_i
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned SW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned DW = (ENTRY_WIDTH > 21) ? ENTRY_WIDTH : 21;
  localparam int unsigned QW = ttt_pkg::QW;

  ttt_pkg::state_e state_q, state_d;

  logic [20:0] adc_div_q;
  logic [15:0] supply_q, pullup_q;
  logic [7:0]  start_q;
  logic [8:0]  tsize_q;

  logic [SW-1:0]          size_q, i_q;
  logic [15:0]            mv_q;
  logic [31:0]            res_q;
  logic [ENTRY_WIDTH-1:0] prev_q, low_q;
  logic [31:0]            temp_q;
  logic [1:0]             stat_q;

  logic                   out_vld_q;
  logic [55:0]            out_data_q;
  logic [1:0]             out_user_q;

  logic                   s_acc;
  logic [AW+7:0]          idx_ext;
  logic [31:0]            val_ext;
  logic                   ram_we;
  logic [ENTRY_WIDTH-1:0] rdata;

  logic                   mul_start, mul_done;
  logic [20:0]            mul_a;
  logic [15:0]            mul_b;
  logic [QW-1:0]          prod;
  logic                   div_start, div_done;
  logic [QW-1:0]          div_dividend, quo;
  logic [DW-1:0]          div_rem, div_divisor;
  logic [5:0]             div_steps;

  logic                   hit, last;
  logic [SW:0]            i_next;
  logic [31:0]            start_ext;
  logic                   sat;
  logic [SW-1:0]          size_eff;
  logic                   out_free;

  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ttt_pkg::ST_IDLE);
  assign out_free        = !out_vld_q || m_axis_tready_i;

  // table load
  assign idx_ext = {{AW{1'b0}}, s_axis_tdata_i[7:0]};
  assign val_ext = {8'd0, s_axis_tdata_i[31:8]};
  assign ram_we  = s_acc && !s_axis_tuser_i && (idx_ext < (AW + 8)'(TABLE_DEPTH));

  ttt_ram #(.WIDTH(ENTRY_WIDTH), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_ext[AW-1:0]),
    .wdata_i(val_ext[ENTRY_WIDTH-1:0]),
    .raddr_i(i_q[AW-1:0]),
    .rdata_o(rdata)
  );

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adc_div_q <= 21'd1024;
      supply_q  <= 16'd5000;
      pullup_q  <= 16'd2200;
      start_q   <= 8'd0;
      tsize_q   <= 9'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ttt_pkg::REG_ADC_DIVISOR: adc_div_q <= cfg_wdata_i;
        ttt_pkg::REG_SUPPLY_MV:   supply_q  <= cfg_wdata_i[15:0];
        ttt_pkg::REG_PULLUP:      pullup_q  <= cfg_wdata_i[15:0];
        ttt_pkg::REG_START_TEMP:  start_q   <= cfg_wdata_i[7:0];
        ttt_pkg::REG_TABLE_SIZE:  tsize_q   <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  // arithmetic units
  assign mul_start = (s_acc && s_axis_tuser_i) || ((state_q == ttt_pkg::ST_DIV1) && div_done
                     && !sat);
  // second product starts on the cycle the millivolt quotient appears
  assign mul_a = (state_q == ttt_pkg::ST_IDLE) ? s_axis_tdata_i[52:32] : {5'd0, quo[15:0]};
  assign mul_b = (state_q == ttt_pkg::ST_IDLE) ? supply_q : pullup_q;

  ttt_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (prod)
  );

  assign sat = (quo >= QW'(supply_q));

  assign hit    = (res_q >= 32'(rdata));
  assign i_next = {1'b0, i_q} + (SW + 1)'(1);
  assign last   = (i_next >= {1'b0, size_q});

  always_comb begin
    div_start    = 1'b0;
    div_dividend = prod;
    div_rem      = '0;
    div_divisor  = DW'(adc_div_q == 21'd0 ? 21'd1 : adc_div_q);
    div_steps    = 6'(QW);
    case (state_q)
      ttt_pkg::ST_MUL1: div_start = mul_done;
      ttt_pkg::ST_MUL2: begin
        div_start   = mul_done;
        div_divisor = DW'(supply_q - mv_q);
      end
      ttt_pkg::ST_CMP: begin
        // fraction: remainder starts below the divisor, so 8 steps give all of it
        div_start    = hit && (i_q != '0);
        div_dividend = '0;
        div_rem      = DW'(res_q - 32'(rdata));
        div_divisor  = DW'(prev_q - rdata);
        div_steps    = 6'd8;
      end
      default: ;
    endcase
  end

  ttt_div #(.DW(DW)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .rem_init_i(div_rem),
    .divisor_i (div_divisor),
    .steps_i   (div_steps),
    .done_o    (div_done),
    .quo_o     (quo)
  );

  assign size_eff  = (tsize_q == 9'd0) ? SW'(1) :
                     ((32'(tsize_q) > 32'(TABLE_DEPTH)) ? SW'(TABLE_DEPTH) : SW'(tsize_q));
  assign start_ext = {{24{start_q[7]}}, start_q};

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ttt_pkg::ST_IDLE: if (s_acc && s_axis_tuser_i) state_d = ttt_pkg::ST_MUL1;
      ttt_pkg::ST_MUL1: if (mul_done) state_d = ttt_pkg::ST_DIV1;
      ttt_pkg::ST_DIV1: if (div_done) state_d = sat ? ttt_pkg::ST_RD : ttt_pkg::ST_MUL2;
      ttt_pkg::ST_MUL2: if (mul_done) state_d = ttt_pkg::ST_DIV2;
      ttt_pkg::ST_DIV2: if (div_done) state_d = ttt_pkg::ST_RD;
      ttt_pkg::ST_RD:   state_d = ttt_pkg::ST_CMP;
      ttt_pkg::ST_CMP: begin
        if (hit) begin
          state_d = (i_q == '0) ? ttt_pkg::ST_DONE : ttt_pkg::ST_FRAC;
        end else begin
          state_d = last ? ttt_pkg::ST_DONE : ttt_pkg::ST_RD;
        end
      end
      ttt_pkg::ST_FRAC: if (div_done) state_d = ttt_pkg::ST_DONE;
      ttt_pkg::ST_DONE: if (out_free) state_d = ttt_pkg::ST_IDLE;
      default:          state_d = ttt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ttt_pkg::ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == ttt_pkg::ST_DONE) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ttt_pkg::ST_IDLE: begin
        size_q <= size_eff;
        i_q    <= '0;
      end
      ttt_pkg::ST_DIV1: begin
        if (div_done) begin
          mv_q  <= quo[15:0];
          res_q <= 32'hFFFF_FFFF;
        end
      end
      ttt_pkg::ST_DIV2: if (div_done) res_q <= quo[31:0];
      ttt_pkg::ST_CMP: begin
        prev_q <= rdata;
        low_q  <= rdata;
        if (hit) begin
          temp_q <= (start_ext + 32'(i_q)) << 8;
          stat_q <= ((i_q == '0) && (res_q != 32'(rdata))) ? ttt_pkg::STAT_ABOVE
                                                          : ttt_pkg::STAT_IN_RANGE;
        end else begin
          i_q <= i_next[SW-1:0];
          if (last) begin
            temp_q <= (start_ext + 32'(size_q) - 32'd1) << 8;
            stat_q <= ttt_pkg::STAT_BELOW;
          end
        end
      end
      ttt_pkg::ST_FRAC: if (div_done) temp_q <= temp_q - {24'd0, quo[7:0]};
      ttt_pkg::ST_DONE: begin
        if (out_free) begin
          out_data_q <= {6'd0, res_q, temp_q[17:0]};
          out_user_q <= stat_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

`include "thermistor_table_temperature_assert.svh"

  // a result only appears after the done state
  `TTT_ASSERT_IMP(a_out_from_done, $rose(out_vld_q), $past(state_q) == ttt_pkg::ST_DONE)
  // the search never reads past the table size in use
  `TTT_ASSERT_IMP(a_search_bound, state_q == ttt_pkg::ST_CMP, i_q < size_q)
  // status code 3 is never produced
  `TTT_ASSERT_IMP(a_status_code, out_vld_q, out_user_q != 2'd3)
  // low_q holds the same entry as prev_q after each compare
  `TTT_ASSERT_NXT(a_low_tracks, state_q == ttt_pkg::ST_CMP, low_q == prev_q)

endmodule

### dv/tb_thermistor_table_temperature.sv
module tb_thermistor_table_temperature;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic [17:0] temp_q8;
    logic [31:0] resistance;
    logic [1:0]  status;
  } reading_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [55:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [20:0] cfg_wdata_i = '0;

  thermistor_table_temperature i_dut (.*);

  // model copy of the registers and the table
  logic [23:0] res_table [DEPTH];
  logic [20:0] divisor_q;
  logic [15:0] supply_q;
  logic [15:0] pullup_q;
  logic [7:0]  start_q;
  logic [8:0]  size_q;

  reading_t readings_due[$];
  int  n_errors = 0;
  int  idle_cycles = 0;
  int  send_gap_pct = 0;
  int  stall_pct = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic reading_t predict_reading(logic [20:0] code);
    logic [63:0] dv, mv, res, hi, lo, frac;
    longint      start, temp;
    int unsigned size, i;
    reading_t    r;
    dv = (divisor_q == 0) ? 64'd1 : 64'(divisor_q);
    mv = 64'(code) * 64'(supply_q) / dv;
    if (mv >= 64'(supply_q)) res = 64'hFFFF_FFFF;
    else res = mv * 64'(pullup_q) / (64'(supply_q) - mv);
    size = (size_q == 0) ? 1 : ((size_q > DEPTH) ? DEPTH : size_q);
    start = longint'($signed(start_q));
    for (i = 0; i < size; i++) begin
      if (res >= 64'(res_table[i])) break;
    end
    r.status = ttt_pkg::STAT_IN_RANGE;
    if (i == 0) begin
      temp = start * 256;
      if (res > 64'(res_table[0])) r.status = ttt_pkg::STAT_ABOVE;
    end else if (i >= size) begin
      temp = (start + size - 1) * 256;
      r.status = ttt_pkg::STAT_BELOW;
    end else begin
      hi = 64'(res_table[i-1]);
      lo = 64'(res_table[i]);
      frac = ((res - lo) << 8) / (hi - lo);
      temp = (longint'(i) + start) * 256 - longint'(frac);
    end
    r.temp_q8 = temp[17:0];
    r.resistance = res[31:0];
    return r;
  endfunction

  // receiver with random stalls
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    reading_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.temp_q8 = m_axis_tdata_o[17:0];
      got.resistance = m_axis_tdata_o[49:18];
      got.status = m_axis_tuser_o;
      if (readings_due.size() == 0) begin
        $display("%0t: unexpected reading temp=%h res=%h st=%0d", $time,
                 got.temp_q8, got.resistance, got.status);
        n_errors++;
      end else begin
        want = readings_due.pop_front();
        if (got.temp_q8 !== want.temp_q8) begin
          $display("%0t: temp_q8 expected %h actual %h", $time, want.temp_q8, got.temp_q8);
          n_errors++;
        end
        if (got.resistance !== want.resistance) begin
          $display("%0t: resistance expected %h actual %h", $time,
                   want.resistance, got.resistance);
          n_errors++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("** thermistor_table_temperature: FAILED **");
      $finish;
    end
  end

  task automatic send_item(logic act, logic [7:0] idx, logic [23:0] val, logic [20:0] code);
    while ($urandom_range(99) < send_gap_pct) @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i = act;
    s_axis_tdata_i = {3'b0, code, val, idx};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (act) readings_due.push_back(predict_reading(code));
    else res_table[idx] = val;
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  task automatic drain();
    while (readings_due.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [20:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      ttt_pkg::REG_ADC_DIVISOR: divisor_q = val;
      ttt_pkg::REG_SUPPLY_MV:   supply_q = val[15:0];
      ttt_pkg::REG_PULLUP:      pullup_q = val[15:0];
      ttt_pkg::REG_START_TEMP:  start_q = val[7:0];
      ttt_pkg::REG_TABLE_SIZE:  size_q = val[8:0];
      default: ;
    endcase
  endtask

  // strictly descending table over the first n entries
  task automatic load_table(int unsigned n, logic [23:0] top);
    logic [23:0] v;
    int unsigned step;
    v = top;
    step = (n > 1) ? int'(top) / n : 1;
    for (int unsigned k = 0; k < n; k++) begin
      send_item(1'b0, 8'(k), v, 21'($urandom));
      v = v - 24'($urandom_range(step > 1 ? step : 1, 1));
    end
  endtask

  task automatic test_directed();
    send_gap_pct = 0;
    stall_pct = 0;
    // reset settings, single entry: above, equal and below
    send_item(1'b0, 8'd0, 24'd2200, 21'd0);
    send_item(1'b1, 8'd0, 24'd0, 21'd512);
    send_item(1'b1, 8'd0, 24'd0, 21'd0);
    send_item(1'b1, 8'd0, 24'd0, 21'd1023);
    send_item(1'b1, 8'd0, 24'd0, 21'h1FFFFF);
    load_table(8, 24'd40000);
    write_reg(ttt_pkg::REG_TABLE_SIZE, 21'd8);
    write_reg(ttt_pkg::REG_START_TEMP, 21'h80);
    send_item(1'b1, 8'd0, 24'd0, 21'd100);
    send_item(1'b1, 8'd0, 24'd0, 21'd1);
    send_item(1'b1, 8'd0, 24'd0, 21'd900);
    write_reg(ttt_pkg::REG_START_TEMP, 21'h7F);
    send_item(1'b1, 8'd0, 24'd0, 21'd300);
    // zero divisor, supply extremes
    write_reg(ttt_pkg::REG_ADC_DIVISOR, 21'd0);
    send_item(1'b1, 8'd0, 24'd0, 21'd0);
    send_item(1'b1, 8'd0, 24'd0, 21'd3);
    write_reg(ttt_pkg::REG_ADC_DIVISOR, 21'h1FFFFF);
    write_reg(ttt_pkg::REG_SUPPLY_MV, 21'hFFFF);
    write_reg(ttt_pkg::REG_PULLUP, 21'hFFFF);
    send_item(1'b1, 8'd0, 24'd0, 21'h1FFFFE);
    send_item(1'b1, 8'd0, 24'd0, 21'h1FFFFF);
    write_reg(ttt_pkg::REG_SUPPLY_MV, 21'd1);
    write_reg(ttt_pkg::REG_PULLUP, 21'd1);
    send_item(1'b1, 8'd0, 24'd0, 21'h1FFFFF);
    // table size zero acts as one
    write_reg(ttt_pkg::REG_TABLE_SIZE, 21'd0);
    send_item(1'b1, 8'd0, 24'd0, 21'd0);
    send_item(1'b0, 8'd255, 24'hFFFFFF, 21'd0);
  endtask

  task automatic test_full_table();
    load_table(256, 24'hFFFFFF);
    write_reg(ttt_pkg::REG_ADC_DIVISOR, 21'd1024);
    write_reg(ttt_pkg::REG_SUPPLY_MV, 21'd5000);
    write_reg(ttt_pkg::REG_PULLUP, 21'd2200);
    write_reg(ttt_pkg::REG_TABLE_SIZE, 21'd256);
    write_reg(ttt_pkg::REG_START_TEMP, 21'hD8);
    for (int k = 0; k < 6; k++) send_item(1'b1, 8'd0, 24'd0, 21'($urandom_range(1023)));
    write_reg(ttt_pkg::REG_TABLE_SIZE, 21'd257);
    send_item(1'b1, 8'd0, 24'd0, 21'd0);
  endtask

  task automatic test_random_phase(int gap, int stall, int n);
    int unsigned sz;
    send_gap_pct = gap;
    stall_pct = stall;
    sz = $urandom_range(24, 2);
    load_table(sz, 24'($urandom_range(24'hFFFFFF, 2000)));
    write_reg(ttt_pkg::REG_TABLE_SIZE, 21'(sz));
    write_reg(ttt_pkg::REG_ADC_DIVISOR, 21'($urandom_range(4096, 1)));
    write_reg(ttt_pkg::REG_SUPPLY_MV, 21'($urandom_range(65535, 1)));
    write_reg(ttt_pkg::REG_PULLUP, 21'($urandom_range(65535, 1)));
    write_reg(ttt_pkg::REG_START_TEMP, 21'($urandom_range(255)));
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0)
        // rewrite a random entry past the size in use
        send_item(1'b0, 8'($urandom_range(255, sz)), 24'($urandom), 21'($urandom));
      else if ($urandom_range(3) == 0)
        send_item(1'b1, 8'($urandom), 24'($urandom), 21'($urandom));
      else
        send_item(1'b1, 8'($urandom), 24'($urandom), 21'($urandom_range(8191)));
    end
  endtask

  task automatic test_pause_until_empty();
    send_item(1'b1, 8'd0, 24'd0, 21'd700);
    drain();
    send_item(1'b1, 8'd0, 24'd0, 21'd200);
  endtask

  initial begin
    for (int k = 0; k < DEPTH; k++) res_table[k] = '0;
    divisor_q = 21'd1024;
    supply_q = 16'd5000;
    pullup_q = 16'd2200;
    start_q = 8'd0;
    size_q = 9'd1;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_full_table();
    for (int p = 0; p < 4; p++) begin
      test_random_phase(0, 0, 70);
      test_random_phase(52, 0, 65);
      test_random_phase(0, 52, 65);
      test_random_phase(30, 30, 65);
    end
    test_pause_until_empty();
    drain();
    repeat (1000) @(negedge clk_i);
    if (n_errors == 0 && readings_due.size() == 0)
      $display("** thermistor_table_temperature: PASSED **");
    else
      $display("** thermistor_table_temperature: FAILED **");
    $finish;
  end

endmodule
